// ===== rtl/vphp_pkg.sv =====
package vphp_pkg;

    localparam int unsigned SINGLE_W = 32;
    localparam int unsigned HALF_W   = 16;
    localparam int unsigned NUM_WORDS = 4;

    localparam logic [22:0] MANT_MASK  = 23'h7FFFFF;
    localparam logic [14:0] HALF_QNAN  = 15'h7E00;
    localparam logic [14:0] HALF_INF   = 15'h7C00;
    localparam logic [14:0] HALF_ZERO  = 15'h0000;
    localparam logic [7:0]  SINGLE_EXP_SPECIAL = 8'hFF;

    // biased single exponent limits for each result class
    localparam logic [7:0] EXP_REBIAS   = 8'd112;
    localparam logic [7:0] EXP_OVERFLOW = 8'd143;
    localparam logic [7:0] EXP_SUB_LOW  = 8'd102;
    localparam logic [7:0] EXP_SUB_HIGH = 8'd112;
    localparam logic [7:0] SUB_SHIFT_BASE = 8'd126;

    localparam logic [2:0] CLS_ZERO = 3'd0;
    localparam logic [2:0] CLS_SUB  = 3'd1;
    localparam logic [2:0] CLS_NORM = 3'd2;
    localparam logic [2:0] CLS_INF  = 3'd3;
    localparam logic [2:0] CLS_NAN  = 3'd4;

    typedef struct packed {
        logic        sgn;
        logic [2:0]  cls;
        logic [4:0]  expo;
        logic [4:0]  shamt;
        logic [22:0] man;
    } dec_t;

    typedef struct packed {
        logic        sgn;
        logic [14:0] mag;
        logic        rnd;
    } rnd_t;

endpackage

// ===== rtl/vphp_if.sv =====
interface vphp_pos_if
    import vphp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SINGLE_W-1:0] pos_x_bits;
    logic [SINGLE_W-1:0] pos_y_bits;
    logic [SINGLE_W-1:0] pos_z_bits;
    logic [SINGLE_W-1:0] pos_w_bits;
    logic                last_vertex;

    modport source (
        output valid, pos_x_bits, pos_y_bits, pos_z_bits, pos_w_bits, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, pos_x_bits, pos_y_bits, pos_z_bits, pos_w_bits, last_vertex,
        output ready
    );
endinterface

interface vphp_half_if
    import vphp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] half_x;
    logic [HALF_W-1:0] half_y;
    logic [HALF_W-1:0] half_z;
    logic [HALF_W-1:0] half_w;
    logic              last_out;

    modport source (
        output valid, half_x, half_y, half_z, half_w, last_out,
        input  ready
    );
    modport sink (
        input  valid, half_x, half_y, half_z, half_w, last_out,
        output ready
    );
endinterface

// ===== rtl/vertex_position_half_packer.sv =====
// channel  | dir | payload                                        | handshake
// pos_ch   | in  | pos_x/y/z/w_bits (4 x 32), last_vertex (1)     | valid/ready
// half_ch  | out | half_x/y/z/w (4 x 16), last_out (1)            | valid/ready
//
// one vertex per cycle sustained while half_ch is ready, each beat passes the s1, s2, s3 registers
// stages: classify and rebias, subnormal shift and field pick, round and pack
// each stage holds its own valid bit and fills a bubble even while the output stalls
// a stall backs up stage by stage, no beat is lost or repeated
// rst_n clears the valid bits only, the data registers carry no reset
module vertex_position_half_packer
    import vphp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vphp_pos_if.sink    pos_ch,
    vphp_half_if.source half_ch
);

    logic [SINGLE_W-1:0] word_in [NUM_WORDS];

    logic   s1_v_reg, s2_v_reg, s3_v_reg;
    logic   s1_last_reg, s2_last_reg, s3_last_reg;
    dec_t   s1_reg [NUM_WORDS];
    rnd_t   s2_reg [NUM_WORDS];
    logic [HALF_W-1:0] s3_reg [NUM_WORDS];

    dec_t   s1_next [NUM_WORDS];
    rnd_t   s2_next [NUM_WORDS];
    logic [HALF_W-1:0] s3_next [NUM_WORDS];

    logic   adv1, adv2, adv3;

    assign word_in[0] = pos_ch.pos_x_bits;
    assign word_in[1] = pos_ch.pos_y_bits;
    assign word_in[2] = pos_ch.pos_z_bits;
    assign word_in[3] = pos_ch.pos_w_bits;

    // a stage may load when it is empty or its content moves on
    assign adv3 = !s3_v_reg || half_ch.ready;
    assign adv2 = !s2_v_reg || adv3;
    assign adv1 = !s1_v_reg || adv2;

    assign pos_ch.ready = adv1;

    for (genvar i = 0; i < NUM_WORDS; i++)
    begin : g_word
        logic [7:0]  exp8;
        logic [22:0] man;
        logic [7:0]  expo_full;
        logic [7:0]  shamt_full;
        logic [23:0] sig;
        logic [23:0] sig_sh;
        logic [4:0]  shamt_m1;

        // stage 1: classify
        always_comb
        begin
            exp8       = word_in[i][30:23];
            man        = word_in[i][22:0] & MANT_MASK;
            expo_full  = exp8 - EXP_REBIAS;
            shamt_full = SUB_SHIFT_BASE - exp8;
            s1_next[i].sgn   = word_in[i][31];
            s1_next[i].expo  = expo_full[4:0];
            s1_next[i].shamt = shamt_full[4:0];
            s1_next[i].man   = man;
            priority if (exp8 == SINGLE_EXP_SPECIAL)
            begin
                s1_next[i].cls = (man != '0) ? CLS_NAN : CLS_INF;
            end
            else if (exp8 >= EXP_OVERFLOW)
            begin
                s1_next[i].cls = CLS_INF;
            end
            else if (exp8 < EXP_SUB_LOW)
            begin
                s1_next[i].cls = CLS_ZERO;
            end
            else if (exp8 <= EXP_SUB_HIGH)
            begin
                s1_next[i].cls = CLS_SUB;
            end
            else
            begin
                s1_next[i].cls = CLS_NORM;
            end
        end

        // stage 2: pick magnitude and round bit
        always_comb
        begin
            sig      = {1'b1, s1_reg[i].man};
            shamt_m1 = s1_reg[i].shamt - 5'd1;
            sig_sh   = sig >> shamt_m1;
            s2_next[i].sgn = s1_reg[i].sgn;
            unique case (s1_reg[i].cls)
                CLS_NAN:
                begin
                    s2_next[i].mag = HALF_QNAN;
                    s2_next[i].rnd = 1'b0;
                end
                CLS_INF:
                begin
                    s2_next[i].mag = HALF_INF;
                    s2_next[i].rnd = 1'b0;
                end
                CLS_SUB:
                begin
                    s2_next[i].mag = {5'd0, sig_sh[10:1]};
                    s2_next[i].rnd = sig_sh[0];
                end
                CLS_NORM:
                begin
                    s2_next[i].mag = {s1_reg[i].expo, s1_reg[i].man[22:13]};
                    s2_next[i].rnd = s1_reg[i].man[12];
                end
                default:
                begin
                    s2_next[i].mag = HALF_ZERO;
                    s2_next[i].rnd = 1'b0;
                end
            endcase
        end

        // stage 3: round, carry may run into the exponent
        always_comb
        begin
            s3_next[i] = {s2_reg[i].sgn, s2_reg[i].mag + {14'd0, s2_reg[i].rnd}};
        end

        always_ff @(posedge clk)
        begin
            if (adv1)
            begin
                s1_reg[i] <= s1_next[i];
            end
            if (adv2)
            begin
                s2_reg[i] <= s2_next[i];
            end
            if (adv3)
            begin
                s3_reg[i] <= s3_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_v_reg <= pos_ch.valid;
            end
            if (adv2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (adv3)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_last_reg <= pos_ch.last_vertex;
        end
        if (adv2)
        begin
            s2_last_reg <= s1_last_reg;
        end
        if (adv3)
        begin
            s3_last_reg <= s2_last_reg;
        end
    end

    assign half_ch.valid    = s3_v_reg;
    assign half_ch.half_x   = s3_reg[0];
    assign half_ch.half_y   = s3_reg[1];
    assign half_ch.half_z   = s3_reg[2];
    assign half_ch.half_w   = s3_reg[3];
    assign half_ch.last_out = s3_last_reg;

`ifndef SYNTH
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        pos_ch.valid && pos_ch.ready |=> s1_v_reg)
        else $error("accepted beat did not reach stage 1");

    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && s2_v_reg && s3_v_reg && !half_ch.ready |-> !pos_ch.ready)
        else $error("input taken while pipeline is full and stalled");

    a_s2_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg && adv3 |=> s3_v_reg)
        else $error("stage 2 beat lost on the way to the output");

    a_nan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && adv2 && s1_reg[0].cls == CLS_NAN
        |=> s2_reg[0].mag == HALF_QNAN && !s2_reg[0].rnd)
        else $error("nan did not come out as quiet nan");
`endif

endmodule
